### design/assert_macros.svh
// Assertion macros used by the checker in dtf_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define DTF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define DTF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### design/dtf_pkg.sv
`timescale 1ns / 1ps

package dtf_pkg;

    // Widths of the result fields.
    localparam int VALUE_W = 48;
    localparam int MAG_W   = 47;

    // Largest magnitude before the sign is applied.
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Configuration register indexes and reset values.
    localparam logic REG_STOP_CHAR   = 1'b0;
    localparam logic REG_REQUIRE_NNG = 1'b1;
    localparam logic [7:0] STOP_CHAR_RESET = 8'd44;

    // Powers of ten used to build the fraction weights.
    localparam logic [63:0] POW10 [0:9] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
        64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
    };

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_NEGATIVE  = 2'd2
    } status_t;

    // Snapshot of a finished number, passed from the parser to the output stage.
    typedef struct packed {
        logic             negative;
        logic             bad_text;
        logic [MAG_W-1:0] mag;
    } dtf_fin_t;

endpackage

### design/dtf_step.sv
`timescale 1ns / 1ps

module dtf_step #(
    parameter int INT_BITS        = 31,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [7:0]         ch,
    input  logic [7:0]         stop_char,
    output logic               term,
    output dtf_pkg::dtf_fin_t  fin
);

    localparam int CW   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int NW   = INT_BITS + 4;
    localparam int PW   = FRAC_BITS + 4;
    localparam int SUMW = INT_BITS + FRAC_BITS + 1;
    localparam int CMPW = (SUMW > dtf_pkg::VALUE_W) ? SUMW : dtf_pkg::VALUE_W;
    localparam logic [INT_BITS-1:0] INT_MAX = '1;

    logic                  sign_seen_reg, sign_seen_next;
    logic                  negative_reg, negative_next;
    logic                  gap_seen_reg, gap_seen_next;
    logic                  point_seen_reg, point_seen_next;
    logic [INT_BITS-1:0]   int_part_reg, int_part_next;
    logic [FRAC_BITS:0]    frac_part_reg, frac_part_next;
    logic [CW-1:0]         frac_count_reg, frac_count_next;
    logic                  bad_text_reg, bad_text_next;

    logic [FRAC_BITS-1:0]  weight [MAX_FRAC_DIGITS];
    logic [FRAC_BITS-1:0]  weight_sel;
    logic                  is_space;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [NW-1:0]         int_mul;
    logic [PW-1:0]         frac_prod;
    logic [PW-1:0]         frac_sum;
    logic [CMPW-1:0]       mag_sum;

    // Fraction weights: weight[k] = round(2^FRAC_BITS / 10^(k+1)), rounding half up.
    for (genvar gk = 0; gk < MAX_FRAC_DIGITS; gk++)
    begin : g_weight
        localparam logic [63:0] P  = dtf_pkg::POW10[gk + 1];
        localparam logic [63:0] WV = ((64'd1 << (FRAC_BITS + 1)) + P) / (64'd2 * P);
        assign weight[gk] = WV[FRAC_BITS-1:0];
    end

    // Character classes.
    assign is_space = (ch == dtf_pkg::CH_SPACE) ||
                      ((ch >= dtf_pkg::CH_TAB) && (ch <= dtf_pkg::CH_CR));
    assign is_digit = (ch >= dtf_pkg::CH_ZERO) && (ch <= dtf_pkg::CH_NINE);
    assign digit    = 4'(ch - dtf_pkg::CH_ZERO);
    assign term     = (ch == dtf_pkg::CH_NUL) || (ch == stop_char);

    // Weight of the next fraction digit.
    always_comb
    begin
        weight_sel = '0;
        for (int k = 0; k < MAX_FRAC_DIGITS; k++)
        begin
            if (frac_count_reg == CW'(k))
            begin
                weight_sel = weight[k];
            end
        end
    end

    // Digit accumulation: integer times ten plus digit, fraction plus digit times weight.
    assign int_mul   = (NW'(int_part_reg) << 3) + (NW'(int_part_reg) << 1) + NW'(digit);
    assign frac_prod = PW'(digit) * PW'(weight_sel);
    assign frac_sum  = PW'(frac_part_reg) + frac_prod;

    // Magnitude of the finished number, saturated.
    assign mag_sum = (CMPW'(int_part_reg) << FRAC_BITS) + CMPW'(frac_part_reg);

    always_comb
    begin
        fin.negative = negative_reg;
        fin.bad_text = bad_text_reg;
        if (mag_sum > CMPW'(dtf_pkg::MAG_MAX))
        begin
            fin.mag = dtf_pkg::MAG_MAX;
        end
        else
        begin
            fin.mag = mag_sum[dtf_pkg::MAG_W-1:0];
        end
    end

    // Parser state update for one character.
    always_comb
    begin
        sign_seen_next  = sign_seen_reg;
        negative_next   = negative_reg;
        gap_seen_next   = gap_seen_reg;
        point_seen_next = point_seen_reg;
        int_part_next   = int_part_reg;
        frac_part_next  = frac_part_reg;
        frac_count_next = frac_count_reg;
        bad_text_next   = bad_text_reg;
        if (go)
        begin
            if (term)
            begin
                // The terminator clears the number.
                sign_seen_next  = 1'b0;
                negative_next   = 1'b0;
                gap_seen_next   = 1'b0;
                point_seen_next = 1'b0;
                int_part_next   = '0;
                frac_part_next  = '0;
                frac_count_next = '0;
                bad_text_next   = 1'b0;
            end
            else if (!bad_text_reg)
            begin
                if (!sign_seen_reg && (ch == dtf_pkg::CH_MINUS))
                begin
                    sign_seen_next = 1'b1;
                    negative_next  = 1'b1;
                end
                else if (is_space)
                begin
                    // Whitespace is skipped before the number and closes it after.
                    if (sign_seen_reg)
                    begin
                        gap_seen_next = 1'b1;
                    end
                end
                else if (!sign_seen_reg && !is_digit)
                begin
                    bad_text_next = 1'b1;
                end
                else if (sign_seen_reg && (ch == dtf_pkg::CH_POINT) && !gap_seen_reg)
                begin
                    if (point_seen_reg)
                    begin
                        bad_text_next = 1'b1;
                    end
                    point_seen_next = 1'b1;
                end
                else if (gap_seen_reg || !is_digit)
                begin
                    bad_text_next = 1'b1;
                end
                else
                begin
                    sign_seen_next = 1'b1;
                    if (!point_seen_reg)
                    begin
                        if (|int_mul[NW-1:INT_BITS])
                        begin
                            int_part_next = INT_MAX;
                        end
                        else
                        begin
                            int_part_next = int_mul[INT_BITS-1:0];
                        end
                    end
                    else if (frac_count_reg < CW'(MAX_FRAC_DIGITS))
                    begin
                        frac_count_next = frac_count_reg + CW'(1);
                        frac_part_next  = frac_sum[FRAC_BITS:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_seen_reg  <= 1'b0;
            negative_reg   <= 1'b0;
            gap_seen_reg   <= 1'b0;
            point_seen_reg <= 1'b0;
            int_part_reg   <= '0;
            frac_part_reg  <= '0;
            frac_count_reg <= '0;
            bad_text_reg   <= 1'b0;
        end
        else
        begin
            sign_seen_reg  <= sign_seen_next;
            negative_reg   <= negative_next;
            gap_seen_reg   <= gap_seen_next;
            point_seen_reg <= point_seen_next;
            int_part_reg   <= int_part_next;
            frac_part_reg  <= frac_part_next;
            frac_count_reg <= frac_count_next;
            bad_text_reg   <= bad_text_next;
        end
    end

endmodule

### design/dtf_finish.sv
`timescale 1ns / 1ps

module dtf_finish (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  dtf_pkg::dtf_fin_t             fin,
    input  logic                          require_nonnegative,
    input  logic                          out_stall,
    output logic                          fin_free,
    output logic                          out_valid,
    output logic [dtf_pkg::VALUE_W-1:0]   value,
    output logic [1:0]                    status
);

    logic                          fin_valid_reg, fin_valid_next;
    dtf_pkg::dtf_fin_t             fin_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [dtf_pkg::VALUE_W-1:0]   value_reg, value_next;
    dtf_pkg::status_t              status_reg, status_next;
    logic                          out_free;
    logic                          fin_move;
    logic [dtf_pkg::VALUE_W-1:0]   mag_ext;

    // Hand-off between the snapshot register and the result register.
    assign out_free       = !out_valid_reg || !out_stall;
    assign fin_move       = fin_valid_reg && out_free;
    assign fin_free       = !fin_valid_reg || out_free;
    assign fin_valid_next = load ? 1'b1 : (fin_move ? 1'b0 : fin_valid_reg);
    assign out_valid_next = fin_move ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Sign and status of the result.
    assign mag_ext = dtf_pkg::VALUE_W'(fin_reg.mag);

    always_comb
    begin
        value_next  = '0;
        status_next = dtf_pkg::STATUS_OK;
        if (fin_reg.bad_text)
        begin
            status_next = dtf_pkg::STATUS_MALFORMED;
        end
        else if (fin_reg.negative && (fin_reg.mag != '0))
        begin
            if (require_nonnegative)
            begin
                status_next = dtf_pkg::STATUS_NEGATIVE;
            end
            else
            begin
                value_next = -mag_ext;
            end
        end
        else
        begin
            value_next = mag_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fin_reg <= fin;
        end
        if (fin_move)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

### design/decimal_text_to_fixed.sv
// A terminator passes through the input register, the snapshot register and the result
// register in that order. One character per cycle is taken while in_stall is low; each
// character is one accumulate step in the parser stage.
// Reset (rst_n, asynchronous, active low) clears the parser state and all valid
// flags, and sets stop_char to ',' and require_nonnegative to 0.
`timescale 1ns / 1ps

module decimal_text_to_fixed #(
    parameter int INT_BITS        = 31,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    ch,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dtf_pkg::VALUE_W-1:0]   value,
    output logic [1:0]                    status,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_data
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        ch_reg;
    logic [7:0]        stop_char_reg;
    logic              require_nng_reg;
    logic              in_take;
    logic              in_go;
    logic              term;
    logic              fin_free;
    dtf_pkg::dtf_fin_t fin;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_char_reg   <= dtf_pkg::STOP_CHAR_RESET;
            require_nng_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtf_pkg::REG_STOP_CHAR)
            begin
                stop_char_reg <= cfg_data;
            end
            if (cfg_index == dtf_pkg::REG_REQUIRE_NNG)
            begin
                require_nng_reg <= cfg_data[0];
            end
        end
    end

    // Input register: a character moves on unless it is a terminator and the
    // snapshot register is still occupied.
    assign in_go         = in_valid_reg && (!term || fin_free);
    assign in_stall      = in_valid_reg && !in_go;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take ? 1'b1 : (in_go ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg <= ch;
        end
    end

    // Character parser.
    dtf_step #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (in_go),
        .ch        (ch_reg),
        .stop_char (stop_char_reg),
        .term      (term),
        .fin       (fin)
    );

    // Sign, status and result register.
    dtf_finish u_finish (
        .clk                 (clk),
        .rst_n               (rst_n),
        .load                (in_go && term),
        .fin                 (fin),
        .require_nonnegative (require_nng_reg),
        .out_stall           (out_stall),
        .fin_free            (fin_free),
        .out_valid           (out_valid),
        .value               (value),
        .status              (status)
    );

endmodule

### design/dtf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  ch,
    input logic        out_valid,
    input logic        out_stall,
    input logic [47:0] value,
    input logic [1:0]  status
);

    // A stalled request stays offered and unchanged.
    `DTF_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(ch))

    // A stalled result stays offered and unchanged.
    `DTF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
    `DTF_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(value) && $stable(status))

    // Any failed result carries a zero value.
    `DTF_ASSERT(a_fail_zero, out_valid && (status != dtf_pkg::STATUS_OK) |-> value == '0)

    // A clock edge seen in reset leaves no result offered at the next edge.
    `DTF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind decimal_text_to_fixed dtf_checker u_dtf_checker (.*);
